// ===== rtl/lps_pkg.sv =====
`default_nettype none
package lps_pkg;

	localparam int NUM_LEDS      = 8;
	localparam int LED_W         = 3;
	localparam int PAT_DEPTH     = 256;
	localparam int PAT_AW        = $clog2(PAT_DEPTH);
	localparam int SUSP_DEPTH    = 8;
	localparam int SUSP_IW       = (SUSP_DEPTH > 1) ? $clog2(SUSP_DEPTH) : 1;
	localparam int SUSP_CW       = $clog2(SUSP_DEPTH + 1);

	localparam logic [31:0] END_COLOR = 32'hFF00_0000;
	localparam logic [15:0] NO_WAIT   = 16'hFFFF;

	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_ADVANCE = 2'd1;
	localparam logic [1:0] MODE_WRITE   = 2'd2;

	localparam logic [1:0] KIND_COLOR = 2'd0;
	localparam logic [1:0] KIND_WAIT  = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;

	typedef struct packed {
		logic [PAT_AW-1:0] base;
		logic [PAT_AW-1:0] ptr;
		logic [15:0]       reps;
		logic [15:0]       counter;
	} task_t;

	typedef struct packed {
		logic [LED_W-1:0] led;
		task_t            tsk;
	} susp_entry_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [LED_W-1:0] pop_led;
		susp_entry_t      push_entry;
	} susp_req_t;

	typedef struct packed {
		logic               full;
		logic               hit;
		susp_entry_t        hit_entry;
		logic [SUSP_CW-1:0] count;
	} susp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lps_susp_queue.sv =====
`default_nettype none
module lps_susp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lps_pkg::susp_req_t req,
	output lps_pkg::susp_stat_t     stat
);
	import lps_pkg::*;

	susp_entry_t        entry_q [SUSP_DEPTH];
	logic [SUSP_CW-1:0] count_q;
	logic               hit;
	logic [SUSP_IW-1:0] hit_idx;

	// The oldest entry for the requested LED wins.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = 0; j < SUSP_DEPTH; j++) begin
			if (!hit && (SUSP_CW'(j) < count_q) && (entry_q[j].led == req.pop_led)) begin
				hit     = 1'b1;
				hit_idx = SUSP_IW'(j);
			end
		end
	end

	assign stat.full      = (count_q == SUSP_CW'(SUSP_DEPTH));
	assign stat.hit       = hit;
	assign stat.hit_entry = entry_q[hit_idx];
	assign stat.count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req.push && !stat.full) begin
			count_q <= count_q + 1'b1;
		end else if (req.pop && hit) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && !stat.full) begin
			entry_q[count_q[SUSP_IW-1:0]] <= req.push_entry;
		end else if (req.pop && hit) begin
			for (int j = 0; j < SUSP_DEPTH - 1; j++) begin
				if (SUSP_IW'(j) >= hit_idx) begin
					entry_q[j] <= entry_q[j+1];
				end
			end
		end
	end

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SUSP_CW'(SUSP_DEPTH))
		else $error("suspend count beyond depth");

	a_push_full_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && stat.full && !req.pop) |=> $stable(count_q))
		else $error("push into a full suspend queue changed the count");

	a_pop_hit_dec : assert property (@(posedge clk) disable iff (!arst_n)
		(req.pop && hit && !req.push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop with a hit did not shrink the queue");

endmodule
`default_nettype wire

// ===== rtl/led_pattern_sequencer_unit.sv =====
`default_nettype none
// LED pattern sequencer. Each input request is one of three kinds, chosen by
// s_tuser: a pattern write stores one (color, hold) entry in the 256-entry
// pattern memory; a start runs a pattern on one LED for a number of passes,
// pushing any task already on that LED into an eight-deep suspend queue (if
// the queue is full that task is dropped and the acknowledgement carries
// status 1); an advance subtracts the elapsed ticks from every active task,
// emits one color update per task that expires, in ascending LED order, and
// closes with a report of the smallest remaining counter (65535 if none).
// The block works on one request at a time; the fourth mode code is taken
// and ignored. An advance walks the eight LED slots in order, one per cycle
// while no task expires; a slot whose task expires also passes through
// ST_RD1 and ST_RD2, because the pattern memory has a single read port with
// a registered read and is read twice, once for the current entry and once
// to look for the end marker. ST_RD1 and ST_REPORT wait while the output
// side stalls. Pattern writes and reads never overlap, since the memory is
// only written between requests. Entries of the pattern memory that were
// never written read back as whatever the memory holds. The forever_repeat
// register is written over the cfg channel, which is always ready.
module led_pattern_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// led_id[2:0], pattern_addr[10:3], entry_color[42:11], entry_hold[58:43],
	// repeat_count[74:59], elapsed[90:75], zero fill above
	input  wire logic [95:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_led[2:0], color[34:3], next_wait[50:35], status[51], zero fill above
	output logic [55:0]      m_tdata,
	// kind[1:0]
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	import lps_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_START  = 7'b0000010,
		ST_WRITE  = 7'b0000100,
		ST_CHECK  = 7'b0001000,
		ST_RD1    = 7'b0010000,
		ST_RD2    = 7'b0100000,
		ST_REPORT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [15:0] forever_q;

	// Latched request fields.
	logic [LED_W-1:0]  led_q;
	logic [PAT_AW-1:0] addr_q;
	logic [31:0]       color_in_q;
	logic [15:0]       hold_in_q;
	logic [15:0]       reps_q;
	logic [15:0]       elapsed_q;

	// Task slots, one per LED.
	logic  valid_q [NUM_LEDS];
	task_t task_q  [NUM_LEDS];

	logic [LED_W-1:0] slot_q, slot_d;
	logic [15:0]      wait_q, wait_d;
	logic [15:0]      hold_q;

	// Pattern memory: {color, hold}, registered read.
	logic [47:0]       pat_mem [PAT_DEPTH];
	logic [47:0]       rd_q;
	logic              rd_en;
	logic [PAT_AW-1:0] rd_addr;
	logic              pat_we;

	// Slot write port.
	logic             slot_we;
	logic [LED_W-1:0] slot_wr_idx;
	logic             slot_wr_valid;
	task_t            slot_wr_task;

	// Output register load.
	logic             out_free;
	logic             out_load;
	logic [1:0]       out_kind;
	logic [LED_W-1:0] out_led;
	logic [31:0]      out_color;
	logic [15:0]      out_wait;
	logic             out_status;
	logic             out_last;

	susp_req_t  sq_req;
	susp_stat_t sq_stat;

	logic             in_accept;
	task_t            cur;
	logic [15:0]      remain;
	logic             end_hit;
	logic             slot_last;

	lps_susp_queue u_susp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.stat   (sq_stat)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign cur       = task_q[slot_q];
	assign remain    = cur.counter - elapsed_q;
	assign end_hit   = (rd_q[47:16] == END_COLOR) && (rd_q[15:0] == 16'd0);
	assign slot_last = (slot_q == LED_W'(NUM_LEDS - 1));

	always_comb begin
		state_d       = state_q;
		slot_d        = slot_q;
		wait_d        = wait_q;
		rd_en         = 1'b0;
		rd_addr       = cur.base + cur.ptr;
		pat_we        = 1'b0;
		slot_we       = 1'b0;
		slot_wr_idx   = slot_q;
		slot_wr_valid = 1'b1;
		slot_wr_task  = cur;
		out_load      = 1'b0;
		out_kind      = KIND_ACK;
		out_led       = '0;
		out_color     = '0;
		out_wait      = '0;
		out_status    = 1'b0;
		out_last      = 1'b1;
		sq_req.push       = 1'b0;
		sq_req.pop        = 1'b0;
		sq_req.pop_led    = slot_q;
		sq_req.push_entry = '{led: led_q, tsk: task_q[led_q]};

		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					priority case (s_tuser)
						MODE_START: state_d = ST_START;
						MODE_WRITE: state_d = ST_WRITE;
						MODE_ADVANCE: begin
							state_d = ST_CHECK;
							slot_d  = '0;
							wait_d  = NO_WAIT;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_START: begin
				if (out_free) begin
					out_load = 1'b1;
					if ({1'b0, led_q} < (LED_W + 1)'(NUM_LEDS)) begin
						// A running task is preempted into the suspend queue, or dropped if it is full.
						sq_req.push  = valid_q[led_q];
						out_status   = valid_q[led_q] && sq_stat.full;
						slot_we      = 1'b1;
						slot_wr_idx  = led_q;
						slot_wr_task = '{base: addr_q, ptr: '0, reps: reps_q, counter: '0};
					end
					state_d = ST_IDLE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					out_load = 1'b1;
					pat_we   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (valid_q[slot_q] && (cur.counter <= elapsed_q)) begin
					rd_en   = 1'b1;
					state_d = ST_RD1;
				end else begin
					if (valid_q[slot_q]) begin
						slot_we              = 1'b1;
						slot_wr_task.counter = remain;
						if (remain < wait_d) begin
							wait_d = remain;
						end
					end
					state_d = slot_last ? ST_REPORT : ST_CHECK;
					slot_d  = slot_q + 1'b1;
				end
			end
			ST_RD1: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_kind  = KIND_COLOR;
					out_led   = slot_q;
					out_color = rd_q[47:16];
					out_last  = 1'b0;
					// Look one entry ahead for the end marker.
					rd_en     = 1'b1;
					rd_addr   = cur.base + cur.ptr + 1'b1;
					state_d   = ST_RD2;
				end
			end
			ST_RD2: begin
				slot_we              = 1'b1;
				slot_wr_task.counter = hold_q;
				slot_wr_task.ptr     = cur.ptr + 1'b1;
				if (end_hit) begin
					slot_wr_task.ptr = '0;
					if (cur.reps != forever_q) begin
						slot_wr_task.reps = cur.reps - 1'b1;
					end
					if (slot_wr_task.reps == 16'd0) begin
						// Task finished: the oldest suspended task of this LED returns.
						slot_wr_valid = 1'b0;
						sq_req.pop    = 1'b1;
						if (sq_stat.hit) begin
							slot_wr_valid = 1'b1;
							slot_wr_task  = sq_stat.hit_entry.tsk;
						end
					end
				end
				if (slot_wr_valid && (slot_wr_task.counter < wait_d)) begin
					wait_d = slot_wr_task.counter;
				end
				state_d = slot_last ? ST_REPORT : ST_CHECK;
				slot_d  = slot_q + 1'b1;
			end
			ST_REPORT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = KIND_WAIT;
					out_wait = wait_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			forever_q <= NO_WAIT;
			m_tvalid  <= 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				valid_q[i] <= 1'b0;
				task_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				forever_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (slot_we) begin
				valid_q[slot_wr_idx] <= slot_wr_valid;
				task_q[slot_wr_idx]  <= slot_wr_task;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		wait_q <= wait_d;
		if (in_accept) begin
			led_q      <= s_tdata[2:0];
			addr_q     <= s_tdata[10:3];
			color_in_q <= s_tdata[42:11];
			hold_in_q  <= s_tdata[58:43];
			reps_q     <= s_tdata[74:59];
			elapsed_q  <= s_tdata[90:75];
		end
		if (state_q == ST_RD1) begin
			hold_q <= rd_q[15:0];
		end
		if (out_load) begin
			m_tuser <= out_kind;
			m_tlast <= out_last;
			m_tdata <= {4'd0, out_status, out_wait, out_color, out_led};
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[addr_q] <= {color_in_q, hold_in_q};
		end
		if (rd_en) begin
			rd_q <= pat_mem[rd_addr];
		end
	end

	a_state_onehot : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_rd2_after_rd1 : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD2) |-> ($past(state_q) == ST_RD1))
		else $error("end-marker check without a preceding entry read");

	a_no_load_when_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !out_load)
		else $error("output register overwritten while a result waits");

endmodule
`default_nettype wire

// ===== verif/lps_checker.sv =====
`default_nettype none
// Watches the request, result and register channels of the sequencer, keeps a
// behavioral copy of its state and compares every result with the prediction.
module lps_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        m_tlast,
	output int               errors,
	output int               pending,
	output int               results_seen
);
	import lps_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  led;
		logic [31:0] color;
		logic [15:0] next_wait;
		logic        status;
		logic        last;
	} lps_result_t;

	lps_result_t expected_q[$];

	logic [31:0] pat_color [PAT_DEPTH];
	logic [15:0] pat_hold [PAT_DEPTH];
	logic        led_on [NUM_LEDS];
	logic [7:0]  led_base [NUM_LEDS];
	logic [7:0]  led_ptr [NUM_LEDS];
	logic [15:0] led_reps [NUM_LEDS];
	int          led_cnt [NUM_LEDS];
	logic [2:0]  sq_led [SUSP_DEPTH];
	logic [7:0]  sq_base [SUSP_DEPTH];
	logic [7:0]  sq_ptr [SUSP_DEPTH];
	logic [15:0] sq_reps [SUSP_DEPTH];
	int          sq_cnt [SUSP_DEPTH];
	int          sq_n;
	logic [15:0] forever_reps;

	task automatic add_result(logic [1:0] kind, logic [2:0] led, logic [31:0] color,
			logic [15:0] nw, logic status, logic last);
		lps_result_t r;
		r.kind = kind;
		r.led = led;
		r.color = color;
		r.next_wait = nw;
		r.status = status;
		r.last = last;
		expected_q.push_back(r);
	endtask

	// Brings back the oldest parked task of this LED, closing the gap in the queue.
	task automatic resume_led(int led);
		for (int i = 0; i < sq_n; i++) begin
			if (sq_led[i] == led) begin
				led_on[led] = 1'b1;
				led_base[led] = sq_base[i];
				led_ptr[led] = sq_ptr[i];
				led_reps[led] = sq_reps[i];
				led_cnt[led] = sq_cnt[i];
				for (int j = i; j + 1 < sq_n; j++) begin
					sq_led[j] = sq_led[j + 1];
					sq_base[j] = sq_base[j + 1];
					sq_ptr[j] = sq_ptr[j + 1];
					sq_reps[j] = sq_reps[j + 1];
					sq_cnt[j] = sq_cnt[j + 1];
				end
				sq_n--;
				return;
			end
		end
	endtask

	task automatic predict_request(logic [1:0] mode, logic [95:0] d);
		logic [2:0]  led;
		logic [7:0]  addr;
		logic [7:0]  a;
		logic [15:0] reps;
		int          elapsed;
		int          smallest;
		logic        st;
		led = d[2:0];
		addr = d[10:3];
		reps = d[74:59];
		elapsed = int'(d[90:75]);
		st = 1'b0;
		case (mode)
			MODE_WRITE: begin
				pat_color[addr] = d[42:11];
				pat_hold[addr] = d[58:43];
				add_result(KIND_ACK, '0, '0, '0, 1'b0, 1'b1);
			end
			MODE_START: begin
				if (led_on[led]) begin
					if (sq_n < SUSP_DEPTH) begin
						sq_led[sq_n] = led;
						sq_base[sq_n] = led_base[led];
						sq_ptr[sq_n] = led_ptr[led];
						sq_reps[sq_n] = led_reps[led];
						sq_cnt[sq_n] = led_cnt[led];
						sq_n++;
					end else begin
						st = 1'b1;
					end
				end
				led_on[led] = 1'b1;
				led_base[led] = addr;
				led_ptr[led] = '0;
				led_reps[led] = reps;
				led_cnt[led] = 0;
				add_result(KIND_ACK, '0, '0, '0, st, 1'b1);
			end
			MODE_ADVANCE: begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (led_on[i]) begin
						led_cnt[i] -= elapsed;
						if (led_cnt[i] <= 0) begin
							a = led_base[i] + led_ptr[i];
							add_result(KIND_COLOR, 3'(i), pat_color[a], '0, 1'b0, 1'b0);
							led_cnt[i] = int'(pat_hold[a]);
							led_ptr[i] = led_ptr[i] + 8'd1;
							a = led_base[i] + led_ptr[i];
							if (pat_color[a] == END_COLOR && pat_hold[a] == 16'd0) begin
								led_ptr[i] = '0;
								if (led_reps[i] != forever_reps)
									led_reps[i] = led_reps[i] - 16'd1;
								if (led_reps[i] == 16'd0) begin
									led_on[i] = 1'b0;
									resume_led(i);
								end
							end
						end
					end
				end
				smallest = int'(NO_WAIT);
				for (int i = 0; i < NUM_LEDS; i++)
					if (led_on[i] && led_cnt[i] >= 0 && led_cnt[i] < smallest)
						smallest = led_cnt[i];
				add_result(KIND_WAIT, '0, '0, smallest[15:0], 1'b0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		lps_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				led_on[i] = 1'b0;
				led_base[i] = '0;
				led_ptr[i] = '0;
				led_reps[i] = '0;
				led_cnt[i] = 0;
			end
			sq_n = 0;
			forever_reps = 16'hFFFF;
			expected_q.delete();
			errors = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				forever_reps = cfg_data;
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("unexpected result kind=%0d data=%h", m_tuser, m_tdata);
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tuser !== exp_r.kind) begin
						$error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
						errors++;
					end
					if (m_tdata[2:0] !== exp_r.led) begin
						$error("out_led: expected %0d, got %0d", exp_r.led, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[34:3] !== exp_r.color) begin
						$error("color: expected %h, got %h", exp_r.color, m_tdata[34:3]);
						errors++;
					end
					if (m_tdata[50:35] !== exp_r.next_wait) begin
						$error("next_wait: expected %0d, got %0d", exp_r.next_wait,
							m_tdata[50:35]);
						errors++;
					end
					if (m_tdata[51] !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, m_tdata[51]);
						errors++;
					end
					if (m_tlast !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, m_tlast);
						errors++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
// Top of the sequencer testbench. This module only makes traffic and gives
// the verdict; all prediction and comparison lives in the checker beside the
// block. The pattern memory is filled completely first, so no request ever
// walks into an entry that was never written.
module tb_top;
	import lps_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 400;

	// Mode code that the block has to ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	// led_id, pattern_addr, entry_color, entry_hold, repeat_count, elapsed, zero fill
	logic [95:0] s_tdata;
	// mode
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// out_led, color, next_wait, status, zero fill
	logic [55:0] m_tdata;
	// kind
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int errors;
	int pending;
	int results_seen;
	int requests_sent;
	int idle_cycles;
	bit sender_idles;
	bit receiver_idles;
	bit long_hold;
	bit run_done;

	led_pattern_sequencer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	lps_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// While receiver_idles is set, the receiver draws a random stall before each result. Once on request it also
	// holds off for a long stretch so that the block backs up into its input side.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold && !held) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held = 1'b1;
			end
			n = receiver_idles ? $urandom_range(0, 19) : 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Reset, or any cycle in which some channel moves a request, a result or a register write, resets the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (!run_done && idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without progress", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] mode, logic [2:0] led, logic [7:0] addr,
			logic [31:0] color, logic [15:0] hold, logic [15:0] reps, logic [15:0] elapsed);
		int gap;
		gap = sender_idles ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'd0, elapsed, reps, hold, color, addr, led};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic write_forever(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pauses the sender until every result is back, then leaves room for a
	// request that yields no result to finish inside the block.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Mostly short holds and small elapsed steps so that tasks fire often;
	// sometimes full-width values to exercise every bit.
	function automatic logic [15:0] pick_hold();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
	endfunction

	function automatic logic [15:0] pick_reps(logic [15:0] fv);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return fv;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic random_requests(int count, logic [15:0] fv);
		int sel;
		logic [7:0] a;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				send_request(MODE_ADVANCE, 3'($urandom), 8'($urandom), 32'($urandom),
					16'($urandom), 16'($urandom),
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50)));
			end else if (sel < 78) begin
				// Patterns mostly begin at the head of an eight-entry block.
				a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31) * 8);
				send_request(MODE_START, 3'($urandom), a, 32'($urandom), 16'($urandom),
					pick_reps(fv), 16'($urandom));
			end else if (sel < 96) begin
				a = 8'($urandom);
				if ($urandom_range(0, 4) == 0)
					send_request(MODE_WRITE, 3'($urandom), a, END_COLOR, 16'd0,
						16'($urandom), 16'($urandom));
				else
					send_request(MODE_WRITE, 3'($urandom), a, 32'($urandom), pick_hold(),
						16'($urandom), 16'($urandom));
			end else begin
				// The unused mode must be swallowed without a result.
				send_request(MODE_UNUSED, 3'($urandom), 8'($urandom), 32'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		s_tvalid = 1'b0;
		s_tdata = 96'd0;
		s_tuser = MODE_WRITE;
		requests_sent = 0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		long_hold = 1'b0;
		run_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_forever(16'hFFFF);

		// Fill the whole pattern memory: an end marker closes each block of
		// eight, every other entry gets a random color and a hold that is mostly short.
		sender_idles = 1'b0;
		for (int a = 0; a < PAT_DEPTH; a++) begin
			if (a % 8 == 7)
				send_request(MODE_WRITE, 3'd0, 8'(a), END_COLOR, 16'd0, 16'd0, 16'd0);
			else
				send_request(MODE_WRITE, 3'd0, 8'(a), 32'($urandom), pick_hold(), 16'd0,
					16'd0);
		end
		sender_idles = 1'b1;

		// Directed corner cases.
		// A marker color with a nonzero hold is an ordinary entry.
		send_request(MODE_WRITE, 3'd7, 8'd17, END_COLOR, 16'd5, 16'hFFFF, 16'hFFFF);
		send_request(MODE_WRITE, 3'd0, 8'd16, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0);
		send_request(MODE_WRITE, 3'd0, 8'd24, 32'h0000_0000, 16'd0, 16'd0, 16'd0);
		// Entry 255 loses its marker so a pattern at 254 runs across address zero.
		send_request(MODE_WRITE, 3'd0, 8'd255, 32'h1234_5678, 16'd3, 16'd0, 16'd0);
		// A fresh task fires even on an advance of zero ticks.
		send_request(MODE_START, 3'd0, 8'd0, 32'd0, 16'd0, 16'd1, 16'd0);
		send_request(MODE_ADVANCE, 3'd0, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0);
		send_request(MODE_START, 3'd7, 8'd254, 32'hFFFF_FFFF, 16'hFFFF, 16'd2, 16'hFFFF);
		send_request(MODE_START, 3'd3, 8'd16, 32'd0, 16'd0, 16'd0, 16'd0);
		send_request(MODE_START, 3'd5, 8'd24, 32'd0, 16'd0, 16'hFFFF, 16'd0);
		send_request(MODE_ADVANCE, 3'd0, 8'd0, 32'd0, 16'd0, 16'd0, 16'd1);
		send_request(MODE_ADVANCE, 3'd7, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF);
		// Preempt LED 3 repeatedly to park tasks and then overflow the queue.
		for (int k = 0; k < 10; k++)
			send_request(MODE_START, 3'd3, 8'(8 * k), 32'd0, 16'd0, 16'd1, 16'd0);
		send_request(MODE_UNUSED, 3'd1, 8'd1, 32'd0, 16'd0, 16'd0, 16'd0);
		for (int k = 0; k < 6; k++)
			send_request(MODE_ADVANCE, 3'd0, 8'd0, 32'd0, 16'd0, 16'd0, 16'd60);
		drain();

		// The forever value is now zero, so a repeat count of zero ends after one pass.
		write_forever(16'd0);
		random_requests(10, 16'd0);
		drain();

		// Receiver holds off while the sender keeps offering requests.
		write_forever(16'd2);
		long_hold = 1'b1;
		sender_idles = 1'b0;
		random_requests(6, 16'd2);
		sender_idles = 1'b1;
		receiver_idles = 1'b0;
		random_requests(6, 16'd2);
		receiver_idles = 1'b1;
		random_requests(6, 16'd2);
		drain();

		write_forever(16'hFFFF);
		random_requests(10, 16'hFFFF);
		drain();

		run_done = 1'b1;
		$display("Sent %0d requests under forever values 65535, 0 and 2,", requests_sent);
		$display("checked %0d results, with queue overflow and long output stalls.",
			results_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
